FILE: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants for the max-priority queue: operation and status codes,
// field widths and parameter defaults.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Parameter defaults.
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_KEY_WIDTH = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_READ     = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
  localparam logic [OP_W-1:0] OP_INCREASE = 3'd3;
  localparam logic [OP_W-1:0] OP_DECREASE = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: rtl/mpq_heap_ram.sv
// ----------------------------------------------------------------------------
// mpq_heap_ram
// Heap storage: one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mpq_heap_ram #(
  parameter int DEPTH = mpq_pkg::DEF_CAPACITY,
  parameter int WIDTH = mpq_pkg::DEF_KEY_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_priority_queue_top
// Bounded max-priority queue of signed keys, held as a binary max-heap.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, op, value) carries one command word;
// the output channel (out_valid, out_stall, top_value, status) returns exactly
// one result word for each command, in order.
// Keys live in a heap memory with two registered read ports. A small
// sequencer walks the heap one level per cycle, with one comparator path for
// sift-down and one shared adder for increase and decrease.
// States from acceptance to the result word in the output register:
//   read max                      S_READ, then S_DONE
//   insert                        S_UP, one level at a time, then S_DONE
//   remove, increase, decrease    S_LOAD, S_DOWN one level at a time, S_DONE
//   empty, full and unused codes  S_DONE directly
// A sift climbs or descends at most ceil(log2(CAPACITY)) levels.
// The block takes one command at a time: in_stall is high from acceptance
// until the result has moved into the output register.
// A stalled result holds in the output register; the sequencer waits in its
// final state until that register is free.
// Reset clears the entry count and both handshakes; the heap memory itself
// is not cleared, as entries above the count are never used.
// ----------------------------------------------------------------------------
module max_priority_queue_top #(
  parameter int CAPACITY  = mpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mpq_pkg::DEF_KEY_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mpq_pkg::OP_W-1:0]            op,
  input  logic signed [mpq_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mpq_pkg::VALUE_W-1:0]  top_value,
  output logic [mpq_pkg::STATUS_W-1:0]        status
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IXW = AW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_UP   = 3'd3;
  localparam logic [2:0] S_DOWN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                          state, state_next;
  logic [CW-1:0]                       count, count_next;
  logic [AW-1:0]                       idx, idx_next;
  logic [KEY_WIDTH-1:0]                key, key_next;
  logic [mpq_pkg::OP_W-1:0]            op_r, op_next;
  logic signed [mpq_pkg::VALUE_W-1:0]  res_top, res_top_next;
  logic [mpq_pkg::STATUS_W-1:0]        res_status, res_status_next;
  logic                                out_load;
  logic                                out_free;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        raddr_a, raddr_b;
  logic [KEY_WIDTH-1:0] rdata_a, rdata_b;

  logic [KEY_WIDTH-1:0] value_key;
  logic [KEY_WIDTH-1:0] sum;
  logic [IXW-1:0]       n_ext, l_ix, r_ix;
  logic                 l_ok, r_ok, l_gt, r_gt;
  logic [KEY_WIDTH-1:0] cand;
  logic [AW-1:0]        up_parent, nx_parent;
  logic [IXW-1:0]       nx_left;

  mpq_heap_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // The input word is sign extended or wrapped to the key width.
  assign value_key = KEY_WIDTH'(value);

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Shared adder for increase and decrease of the maximum.
  assign sum = (op_r == mpq_pkg::OP_DECREASE) ? (rdata_a - key) : (rdata_a + key);

  // Child indices and the shared comparator path for one level of sift-down.
  assign n_ext = IXW'(count);
  assign l_ix  = {1'b0, idx, 1'b1};
  assign r_ix  = l_ix + IXW'(1);
  assign l_ok  = (l_ix < n_ext);
  assign r_ok  = (r_ix < n_ext);
  assign l_gt  = l_ok && ($signed(rdata_a) > $signed(key));
  assign cand  = l_gt ? rdata_a : key;
  assign r_gt  = r_ok && ($signed(rdata_b) > $signed(cand));

  assign up_parent = (idx - AW'(1)) >> 1;

  // Sequencer.
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    key_next        = key;
    op_next         = op_r;
    res_top_next    = res_top;
    res_status_next = res_status;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = key;
    out_load        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next         = op;
          key_next        = value_key;
          res_top_next    = '0;
          res_status_next = mpq_pkg::ST_OK;
          state_next      = S_DONE;
          unique case (op) inside
            mpq_pkg::OP_READ: begin
              if (count == '0) begin
                res_status_next = mpq_pkg::ST_EMPTY;
              end else begin
                state_next = S_READ;
              end
            end
            mpq_pkg::OP_INSERT: begin
              if (count == CAP_C) begin
                res_status_next = mpq_pkg::ST_FULL;
              end else begin
                idx_next   = count[AW-1:0];
                count_next = count + CW'(1);
                state_next = S_UP;
              end
            end
            mpq_pkg::OP_REMOVE: begin
              if (count == '0) begin
                res_status_next = mpq_pkg::ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
                state_next = S_LOAD;
              end
            end
            mpq_pkg::OP_INCREASE, mpq_pkg::OP_DECREASE: begin
              if (count == '0) begin
                res_status_next = mpq_pkg::ST_EMPTY;
              end else begin
                state_next = S_LOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_top_next = 32'($signed(rdata_a));
        state_next   = S_DONE;
      end
      S_LOAD: begin
        // Moving key: the last entry for a remove, the adjusted root otherwise.
        key_next   = (op_r == mpq_pkg::OP_REMOVE) ? rdata_a : sum;
        idx_next   = '0;
        state_next = S_DOWN;
      end
      S_UP: begin
        if (idx == '0) begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end else if ($signed(key) > $signed(rdata_a)) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_a;
          idx_next  = up_parent;
        end else begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DOWN: begin
        mem_we = 1'b1;
        if (r_gt) begin
          mem_wdata = rdata_b;
          idx_next  = r_ix[AW-1:0];
        end else if (l_gt) begin
          mem_wdata = rdata_a;
          idx_next  = l_ix[AW-1:0];
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Read addresses follow the state and heap position of the next cycle.
  assign nx_parent = (idx_next - AW'(1)) >> 1;
  assign nx_left   = {1'b0, idx_next, 1'b1};

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (state_next)
      S_UP: begin
        raddr_a = nx_parent;
      end
      S_DOWN: begin
        raddr_a = nx_left[AW-1:0];
        raddr_b = AW'(nx_left + IXW'(1));
      end
      S_LOAD: begin
        raddr_a = (op_next == mpq_pkg::OP_REMOVE) ? count_next[AW-1:0] : '0;
      end
      default: begin
        raddr_a = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    op_r       <= op_next;
    res_top    <= res_top_next;
    res_status <= res_status_next;
    if (out_load) begin
      top_value <= res_top;
      status    <= res_status;
    end
  end

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  // An insert below capacity adds exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && op == mpq_pkg::OP_INSERT && count != CAP_C)
      |=> (count == $past(count) + CW'(1)))
    else $error("insert did not add one entry");

  // The heap is never written while the sequencer is idle or finishing.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("heap written outside a sift");

  // A non-zero maximum is only reported with an ok status.
  a_top_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && top_value != '0) |-> (status == mpq_pkg::ST_OK))
    else $error("maximum reported with an error status");

endmodule
